FILE: rtl/hcp_pkg.sv
`default_nettype none

package hcp_pkg;

	// Parameter slots in the command; legal range 1 to 8
	localparam int MAX_PARAMETERS = 3;
	// Value fields on the result port
	localparam int OUT_VALUES = 3;
	// Slots of storage; entries past MAX_PARAMETERS are never written and stay zero
	localparam int STORE_DEPTH = (MAX_PARAMETERS > OUT_VALUES) ? MAX_PARAMETERS : OUT_VALUES;
	localparam int PHASE_W = $clog2(MAX_PARAMETERS + 1);

	localparam logic [PHASE_W-1:0] PHASE_NAME = '0;
	localparam logic [PHASE_W-1:0] PHASE_FIRST = PHASE_W'(1);
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(MAX_PARAMETERS);

	localparam logic [31:0] HASH_SEED = 32'd5381;

	localparam logic [7:0] CHAR_DOT = 8'h2E;
	localparam logic [7:0] CHAR_UPPER_LO = 8'h40;
	localparam logic [7:0] CHAR_UPPER_HI = 8'h5B;
	localparam logic [7:0] CHAR_LOWER_LO = 8'h60;
	localparam logic [7:0] CHAR_LOWER_HI = 8'h7B;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_OPEN = 8'h28;
	localparam logic [7:0] CHAR_CLOSE = 8'h29;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_UNEXPECTED = 2'd1,
		ERR_TOO_MANY = 2'd2
	} err_code_t;

	typedef struct packed {
		logic [31:0] name_hash;
		logic [OUT_VALUES-1:0][15:0] values;
		err_code_t error_code;
	} result_t;

	function automatic logic is_name_byte(input logic [7:0] b);
		return (b == CHAR_DOT) ||
			((b > CHAR_UPPER_LO) && (b < CHAR_UPPER_HI)) ||
			((b > CHAR_LOWER_LO) && (b < CHAR_LOWER_HI));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/hashed_command_parser.sv
// Flow: an accepted byte is held in byte_s1 and decoded there; a result it
// causes is written to the result register when that byte leaves byte_s1.
// Throughput: one byte per cycle; the input stalls only while a byte would
// produce a result and the single result register is still held by out_stall.
// Reset: arst_n clears all control state at once; hash returns to 5381,
// parameters to zero, parser to the name phase. No warm-up sweep.
`default_nettype none

module hashed_command_parser (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [7:0] data_byte,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [31:0] name_hash,
	output logic [15:0] first_value,
	output logic [15:0] second_value,
	output logic [15:0] third_value,
	output logic [1:0] error_code
);
	import hcp_pkg::*;

	logic out_free;
	logic res_push;
	result_t res;
	result_t out_res;

	hcp_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_free(out_free),
		.res_push(res_push),
		.res(res)
	);

	hcp_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.res_push(res_push),
		.res(res),
		.out_free(out_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res(out_res)
	);

	assign name_hash = out_res.name_hash;
	assign first_value = out_res.values[0];
	assign second_value = out_res.values[1];
	assign third_value = out_res.values[2];
	assign error_code = out_res.error_code;

endmodule

`default_nettype wire

FILE: rtl/hcp_core.sv
`default_nettype none

module hcp_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic out_free,
	output logic res_push,
	output hcp_pkg::result_t res
);
	import hcp_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;

	logic [31:0] hash_q, hash_d;
	logic [STORE_DEPTH-1:0][15:0] vals_q, vals_d;
	logic [PHASE_W-1:0] phase_q, phase_d;
	logic emits;
	logic fire;

	always_comb begin
		hash_d = hash_q;
		vals_d = vals_q;
		phase_d = phase_q;
		emits = 1'b0;
		res = '{name_hash: '0, values: '0, error_code: ERR_NONE};

		if (phase_q == PHASE_NAME) begin
			if (is_name_byte(byte_s1)) begin
				hash_d = (hash_q << 5) + hash_q + {24'b0, byte_s1};
			end else begin
				phase_d = PHASE_FIRST;
			end
		end else begin
			priority if (byte_s1 == CHAR_OPEN) begin
				// stray open parenthesis: drop
			end else if (byte_s1 == CHAR_CLOSE) begin
				emits = 1'b1;
				res.name_hash = hash_q;
				for (int j = 0; j < OUT_VALUES; j++) begin
					res.values[j] = vals_q[j];
				end
			end else if (byte_s1 == CHAR_COMMA) begin
				if (phase_q == PHASE_LAST) begin
					emits = 1'b1;
					res.error_code = ERR_TOO_MANY;
				end else begin
					phase_d = phase_q + PHASE_W'(1);
				end
			end else if (is_digit(byte_s1)) begin
				for (int j = 0; j < MAX_PARAMETERS; j++) begin
					if (phase_q == PHASE_W'(j + 1)) begin
						vals_d[j] = (vals_q[j] << 3) + (vals_q[j] << 1) +
							{12'b0, byte_s1[3:0]};
					end
				end
			end else begin
				emits = 1'b1;
				res.error_code = ERR_UNEXPECTED;
			end
		end

		// restart after every result
		if (emits) begin
			hash_d = HASH_SEED;
			vals_d = '0;
			phase_d = PHASE_NAME;
		end
	end

	// hold the byte only when it has a result and the result register is full and stalled
	assign in_stall = valid_s1 && emits && !out_free;
	assign fire = valid_s1 && !in_stall;
	assign res_push = fire && emits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
			vals_q <= '0;
			phase_q <= PHASE_NAME;
		end else if (fire) begin
			hash_q <= hash_d;
			vals_q <= vals_d;
			phase_q <= phase_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/hcp_out_reg.sv
`default_nettype none

module hcp_out_reg (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_push,
	input  wire hcp_pkg::result_t res,
	output logic out_free,
	output logic out_valid,
	input  wire logic out_stall,
	output hcp_pkg::result_t out_res
);
	import hcp_pkg::*;

	logic valid_q;
	result_t res_q;

	assign out_free = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/hcp_checker.sv
`default_nettype none

module hcp_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic out_valid,
	input  wire logic out_stall,
	input  wire logic [31:0] name_hash,
	input  wire logic [15:0] first_value,
	input  wire logic [15:0] second_value,
	input  wire logic [15:0] third_value,
	input  wire logic [1:0] error_code
);
	import hcp_pkg::*;

	// input backs up only behind a full, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while result side free");

	// a stalled input transfer keeps its byte
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(data_byte)))
		else $error("stalled input byte changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (error_code != ERR_NONE)) |->
			(name_hash == 32'd0 && first_value == 16'd0 &&
			 second_value == 16'd0 && third_value == 16'd0))
		else $error("error result carries nonzero payload");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_code == ERR_NONE || error_code == ERR_UNEXPECTED ||
			error_code == ERR_TOO_MANY))
		else $error("undefined error code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(name_hash) && $stable(error_code)))
		else $error("stalled result changed");

endmodule

bind hashed_command_parser hcp_checker u_hcp_checker (.*);

`default_nettype wire
